>>> rtl/psc_pkg.sv
// Shared types and constants for the ping-pong sample capture block.
// Holds word layouts, codes and sizes; no dependencies.
`default_nettype none

package psc_pkg;

	localparam int BUFFER_DEPTH = 16384;
	localparam int MAX_CHANNELS = 64;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int TOTAL_W      = ADDR_W + 1;
	localparam int CH_W         = 7;
	localparam int FR_W         = 11;
	localparam int SAMPLE_W     = 16;
	localparam int BLOCK_W      = 32;
	localparam int COUNT_W      = 32;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 11;
	localparam int QUEUE_DEPTH  = 4;

	localparam int RESET_CHANNELS = 1;
	localparam int RESET_FRAMES   = (BUFFER_DEPTH < 100) ? BUFFER_DEPTH : 100;

	// full counts are kept as count minus one
	localparam logic [COUNT_W-1:0] COUNT_MINUS_ONE = '1;

	localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES        = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SECURITY      = 2'd2;

	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_BAD_CHANNEL = 2'd1;
	localparam logic [1:0] STATUS_BAD_FRAME   = 2'd2;
	localparam logic [1:0] STATUS_NO_BUFFER   = 2'd3;

	localparam logic [1:0] WARN_NONE   = 2'd0;
	localparam logic [1:0] WARN_BEHIND = 2'd1;
	localparam logic [1:0] WARN_AHEAD  = 2'd2;

	typedef enum logic [1:0] {
		OP_START,
		OP_SAMPLE,
		OP_STOP,
		OP_READ
	} opcode_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_WRITE,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		opcode_t                    opcode;
		logic signed [SAMPLE_W-1:0] sample_value;
		logic                       block_start;
		logic [BLOCK_W-1:0]         block_number;
		logic [FR_W-1:0]            frame_index;
		logic [CH_W-1:0]            channel_index;
		logic                       final_read;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] read_value;
		logic [1:0]                 status;
		logic                       overflow;
		logic                       buffer_done;
		logic                       done_buffer;
		logic [1:0]                 count_warning;
	} out_word_t;

	// effective configuration seen by the front end
	typedef struct packed {
		logic [CH_W-1:0]    channels;
		logic [FR_W-1:0]    frames;
		logic [TOTAL_W-1:0] total;
		logic               security;
		logic               busy;
	} cfg_t;

	// queue entry: memory operation plus the finished result fields
	typedef struct packed {
		cmd_kind_t          kind;
		logic               sel;
		logic [ADDR_W-1:0]  addr;
		logic [SAMPLE_W-1:0] wdata;
		out_word_t          res;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/psc_cfg.sv
// Configuration registers and effective-size unit for the capture block.
// Derives channels, frames and buffer total with a bit-serial divider; uses psc_pkg.
`default_nettype none

module psc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [psc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output psc_pkg::cfg_t                    cfg
);

	localparam int CH_W    = psc_pkg::CH_W;
	localparam int FR_W    = psc_pkg::FR_W;
	localparam int DIV_W   = psc_pkg::TOTAL_W;
	localparam int STEP_W  = $clog2(DIV_W + 1);
	localparam int CMP_W   = (DIV_W > FR_W) ? DIV_W : FR_W;
	localparam int PROD_W  = FR_W + CH_W;
	localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(psc_pkg::BUFFER_DEPTH);

	logic [CH_W-1:0]                 cfg_channels_q;
	logic [FR_W-1:0]                 cfg_frames_q;
	logic                            security_q;
	logic                            busy_q;
	logic [STEP_W-1:0]               step_q;
	logic [DIV_W-1:0]                dvd_q;
	logic [DIV_W-1:0]                quo_q;
	logic [CH_W-1:0]                 rem_q;
	logic [CH_W-1:0]                 channels_q;
	logic [FR_W-1:0]                 frames_q;
	logic [psc_pkg::TOTAL_W-1:0]     total_q;

	logic [CH_W-1:0]                 eff_ch;
	logic [CH_W:0]                   trial;
	logic [CH_W:0]                   diff;
	logic                            ge;
	logic [CH_W-1:0]                 rem_next;
	logic [DIV_W-1:0]                lim;
	logic [FR_W-1:0]                 fr_c;
	logic [PROD_W-1:0]               prod;
	logic                            div_step;

	always_comb begin
		eff_ch = cfg_channels_q;
		if (cfg_channels_q == '0) begin
			eff_ch = CH_W'(1);
		end else if (int'(cfg_channels_q) > psc_pkg::MAX_CHANNELS) begin
			eff_ch = CH_W'(psc_pkg::MAX_CHANNELS);
		end
	end

	// one quotient bit per cycle, restoring form
	always_comb begin
		trial    = {rem_q, dvd_q[DIV_W-1]};
		diff     = trial - {1'b0, eff_ch};
		ge       = (trial >= {1'b0, eff_ch});
		rem_next = ge ? diff[CH_W-1:0] : trial[CH_W-1:0];
		div_step = busy_q && (step_q != STEP_W'(DIV_W));
	end

	always_comb begin
		lim = (quo_q == '0) ? DIV_W'(1) : quo_q;
		fr_c = cfg_frames_q;
		if (CMP_W'(cfg_frames_q) > CMP_W'(lim)) begin
			fr_c = FR_W'(lim);
		end
		if (fr_c == '0) begin
			fr_c = FR_W'(1);
		end
		prod = PROD_W'(fr_c) * PROD_W'(eff_ch);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_channels_q <= CH_W'(psc_pkg::RESET_CHANNELS);
			cfg_frames_q   <= FR_W'(psc_pkg::RESET_FRAMES);
			security_q     <= 1'b0;
			busy_q         <= 1'b0;
			step_q         <= '0;
			channels_q     <= CH_W'(psc_pkg::RESET_CHANNELS);
			frames_q       <= FR_W'(psc_pkg::RESET_FRAMES);
			total_q        <= psc_pkg::TOTAL_W'(psc_pkg::RESET_FRAMES
				* psc_pkg::RESET_CHANNELS);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					psc_pkg::CFG_CHANNEL_COUNT: cfg_channels_q <= cfg_data[CH_W-1:0];
					psc_pkg::CFG_FRAMES:        cfg_frames_q   <= cfg_data[FR_W-1:0];
					psc_pkg::CFG_SECURITY:      security_q     <= cfg_data[0];
					default: ;
				endcase
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (div_step) begin
					step_q <= step_q + STEP_W'(1);
				end else begin
					busy_q     <= 1'b0;
					channels_q <= eff_ch;
					frames_q   <= fr_c;
					total_q    <= psc_pkg::TOTAL_W'(prod);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_we) begin
			dvd_q <= DIVIDEND;
			quo_q <= '0;
			rem_q <= '0;
		end else if (div_step) begin
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	always_comb begin
		cfg.channels = channels_q;
		cfg.frames   = frames_q;
		cfg.total    = total_q;
		cfg.security = security_q;
		cfg.busy     = busy_q;
	end

endmodule

`default_nettype wire

>>> rtl/psc_front.sv
// Front end: takes input words, keeps pointer, block and counter state,
// and turns each word into a queue entry with its result fields. Uses psc_pkg.
`default_nettype none

module psc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  psc_pkg::in_word_t  in_word,
	input  psc_pkg::cfg_t      cfg,
	input  logic               q_full,
	output logic               push,
	output psc_pkg::cmd_t      cmd
);

	localparam int ADDR_W  = psc_pkg::ADDR_W;
	localparam int TOTAL_W = psc_pkg::TOTAL_W;
	localparam int CH_W    = psc_pkg::CH_W;
	localparam int FR_W    = psc_pkg::FR_W;
	localparam int BLOCK_W = psc_pkg::BLOCK_W;
	localparam int COUNT_W = psc_pkg::COUNT_W;
	localparam int PROD_W  = FR_W + CH_W;

	logic [ADDR_W-1:0]   wp_q,          wp_d;
	logic                filling_b_q,   filling_b_d;
	logic                any_q,         any_d;
	logic [BLOCK_W-1:0]  last_block_q,  last_block_d;
	logic                lbv_q,         lbv_d;
	logic [COUNT_W-1:0]  full_m1_a_q,   full_m1_a_d;
	logic [COUNT_W-1:0]  full_m1_b_q,   full_m1_b_d;
	logic [COUNT_W-1:0]  ret_a_q,       ret_a_d;
	logic [COUNT_W-1:0]  ret_b_q,       ret_b_d;

	logic [TOTAL_W-1:0]  wp_inc;
	logic                rb;
	logic [FR_W-1:0]     frame_m1;
	logic [CH_W-1:0]     chan_m1;
	logic [PROD_W-1:0]   addr_full;
	logic [COUNT_W-1:0]  ret_sel;
	logic [COUNT_W-1:0]  exp_sel;
	logic [COUNT_W-1:0]  ret_new;

	assign in_stall = cfg.busy || q_full;
	assign push     = in_valid && !in_stall;

	always_comb begin
		wp_d         = wp_q;
		filling_b_d  = filling_b_q;
		any_d        = any_q;
		last_block_d = last_block_q;
		lbv_d        = lbv_q;
		full_m1_a_d  = full_m1_a_q;
		full_m1_b_d  = full_m1_b_q;
		ret_a_d      = ret_a_q;
		ret_b_d      = ret_b_q;

		wp_inc    = {1'b0, wp_q} + TOTAL_W'(1);
		rb        = !filling_b_q;
		frame_m1  = in_word.frame_index - FR_W'(1);
		chan_m1   = in_word.channel_index - CH_W'(1);
		addr_full = PROD_W'(frame_m1) * PROD_W'(cfg.channels) + PROD_W'(chan_m1);
		ret_sel   = rb ? ret_b_q : ret_a_q;
		exp_sel   = rb ? full_m1_b_q : full_m1_a_q;
		ret_new   = ret_sel;

		cmd                   = '0;
		cmd.kind              = psc_pkg::CMD_NONE;
		cmd.sel               = filling_b_q;
		cmd.addr              = wp_q;
		cmd.wdata             = in_word.sample_value;
		cmd.res.status        = psc_pkg::STATUS_OK;
		cmd.res.count_warning = psc_pkg::WARN_NONE;

		case (in_word.opcode)
			psc_pkg::OP_START: begin
				lbv_d = 1'b0;
			end
			psc_pkg::OP_SAMPLE: begin
				if (in_word.block_start) begin
					cmd.res.overflow = lbv_q && ({1'b0, in_word.block_number}
						> ({1'b0, last_block_q} + (BLOCK_W + 1)'(1)));
					last_block_d = in_word.block_number;
					lbv_d        = 1'b1;
				end
				cmd.kind = psc_pkg::CMD_WRITE;
				if (wp_inc >= cfg.total) begin
					cmd.res.buffer_done = 1'b1;
					cmd.res.done_buffer = filling_b_q;
					if (filling_b_q) begin
						full_m1_b_d = full_m1_b_q + COUNT_W'(1);
					end else begin
						full_m1_a_d = full_m1_a_q + COUNT_W'(1);
					end
					filling_b_d = !filling_b_q;
					any_d       = 1'b1;
					wp_d        = '0;
				end else begin
					wp_d = wp_inc[ADDR_W-1:0];
				end
			end
			psc_pkg::OP_STOP: begin
				wp_d        = '0;
				filling_b_d = 1'b0;
				any_d       = 1'b0;
				full_m1_a_d = psc_pkg::COUNT_MINUS_ONE;
				full_m1_b_d = psc_pkg::COUNT_MINUS_ONE;
			end
			psc_pkg::OP_READ: begin
				cmd.res.done_buffer = any_q && rb;
				if (in_word.channel_index == '0 || in_word.channel_index > cfg.channels) begin
					cmd.res.status = psc_pkg::STATUS_BAD_CHANNEL;
				end else if (in_word.frame_index == '0
					|| in_word.frame_index > cfg.frames) begin
					cmd.res.status = psc_pkg::STATUS_BAD_FRAME;
				end else if (!any_q) begin
					cmd.res.status = psc_pkg::STATUS_NO_BUFFER;
				end else begin
					cmd.kind = psc_pkg::CMD_READ;
					cmd.sel  = rb;
					cmd.addr = addr_full[ADDR_W-1:0];
					if (cfg.security) begin
						if (exp_sel > ret_sel) begin
							cmd.res.count_warning = psc_pkg::WARN_BEHIND;
							ret_new = exp_sel;
						end else if (exp_sel < ret_sel) begin
							cmd.res.count_warning = psc_pkg::WARN_AHEAD;
							ret_new = exp_sel;
						end
					end
					if (in_word.frame_index == cfg.frames && in_word.final_read) begin
						ret_new = ret_new + COUNT_W'(1);
					end
					if (rb) begin
						ret_b_d = ret_new;
					end else begin
						ret_a_d = ret_new;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q         <= '0;
			filling_b_q  <= 1'b0;
			any_q        <= 1'b0;
			last_block_q <= '0;
			lbv_q        <= 1'b0;
			full_m1_a_q  <= psc_pkg::COUNT_MINUS_ONE;
			full_m1_b_q  <= psc_pkg::COUNT_MINUS_ONE;
			ret_a_q      <= '0;
			ret_b_q      <= '0;
		end else if (push) begin
			wp_q         <= wp_d;
			filling_b_q  <= filling_b_d;
			any_q        <= any_d;
			last_block_q <= last_block_d;
			lbv_q        <= lbv_d;
			full_m1_a_q  <= full_m1_a_d;
			full_m1_b_q  <= full_m1_b_d;
			ret_a_q      <= ret_a_d;
			ret_b_q      <= ret_b_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/psc_queue.sv
// Short FIFO of memory commands between front and back end.
// Flop storage, one push and one pop per cycle; uses psc_pkg.
`default_nettype none

module psc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  psc_pkg::cmd_t  push_cmd,
	input  logic           pop,
	output psc_pkg::cmd_t  head,
	output logic           empty,
	output logic           full
);

	localparam int DEPTH = psc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	psc_pkg::cmd_t     entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head  = entries_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

>>> rtl/psc_back.sv
// Back end: owns both sample buffers as one memory, carries out queued
// writes and reads in order, and holds the result word. Uses psc_pkg.
`default_nettype none

module psc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  psc_pkg::cmd_t       head,
	input  logic                empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output psc_pkg::out_word_t  out_word
);

	localparam int MEM_AW = psc_pkg::ADDR_W + 1;
	localparam int MEM_DEPTH = 2 * psc_pkg::BUFFER_DEPTH;

	// upper half is buffer b
	logic [psc_pkg::SAMPLE_W-1:0] mem [MEM_DEPTH];

	logic [MEM_AW-1:0]             mem_addr;
	logic                          v_s1;
	psc_pkg::cmd_t                 cmd_s1;
	logic [psc_pkg::SAMPLE_W-1:0]  rdata_s1;

	assign pop      = !empty && (!v_s1 || !out_stall);
	assign mem_addr = {head.sel, head.addr};

	always_ff @(posedge clk) begin
		if (pop && head.kind == psc_pkg::CMD_WRITE) begin
			mem[mem_addr] <= head.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == psc_pkg::CMD_READ) begin
			rdata_s1 <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pop) begin
			v_s1 <= 1'b1;
		end else if (!out_stall) begin
			v_s1 <= 1'b0;
		end
	end

	always_comb begin
		out_word = cmd_s1.res;
		out_word.read_value = (cmd_s1.kind == psc_pkg::CMD_READ) ? rdata_s1 : '0;
	end

	assign out_valid = v_s1;

endmodule

`default_nettype wire

>>> rtl/pingpong_sample_capture_top.sv
// Top level of the ping-pong sample capture block.
// Connects psc_cfg, psc_front, psc_queue and psc_back; uses psc_pkg.
//
// channel | handshake            | word
// --------+----------------------+---------------------------------------
// in      | in_valid / in_stall  | in_word (opcode, sample, block, read)
// out     | out_valid / out_stall| out_word (value, status, flags)
// cfg     | cfg_we               | cfg_index, cfg_data (no read-back)
//
// One word per cycle sustained while neither stall is raised; every input word gives one output word.
// Path: front end into queue, then one memory access into the output register.
// After any config write the input stalls while the bit-serial divider
// derives frames per buffer (buffer depth / channels).
// Output stall backs up the queue; input stalls once the queue is full.
// Reset clears control state; buffer contents are undefined until written.
`default_nettype none

module pingpong_sample_capture_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  psc_pkg::in_word_t                in_word,
	output logic                             out_valid,
	input  logic                             out_stall,
	output psc_pkg::out_word_t               out_word,
	input  logic                             cfg_we,
	input  logic [psc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	psc_pkg::cfg_t  cfg;
	psc_pkg::cmd_t  push_cmd;
	psc_pkg::cmd_t  head;
	logic           push;
	logic           pop;
	logic           q_empty;
	logic           q_full;

	psc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	psc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	psc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	psc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire
